FILE: rtl/dsvm_pkg.sv
// Package for the drum sample voice mixer: sizes, widths, command codes,
// controller states, control/status structs and small arithmetic helpers.
// No dependencies.
package dsvm_pkg;

    localparam int VOICE_COUNT      = 8;
    localparam int QUEUE_DEPTH      = 16;
    localparam int CHUNK_FRAMES     = 256;
    localparam int SAMPLE_FRAMES    = 262144;
    localparam int LAYER_COUNT      = 6;
    localparam int INSTRUMENT_COUNT = 4;
    localparam int LAYER_SPLIT      = 6;
    localparam int MAP_REGS         = 4;
    localparam int MAPPED = (MAP_REGS < INSTRUMENT_COUNT) ? MAP_REGS : INSTRUMENT_COUNT;
    localparam int DESC_COUNT       = INSTRUMENT_COUNT * LAYER_COUNT;

    localparam int SA_W  = (SAMPLE_FRAMES > 1) ? $clog2(SAMPLE_FRAMES) : 1;
    localparam int EXT_W = 26;
    localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VC_W  = $clog2(VOICE_COUNT + 1);
    localparam int LI_W  = (DESC_COUNT > 1) ? $clog2(DESC_COUNT) : 1;
    localparam int IN_W  = (INSTRUMENT_COUNT > 1) ? $clog2(INSTRUMENT_COUNT) : 1;
    localparam int CH_W  = (CHUNK_FRAMES > 1) ? $clog2(CHUNK_FRAMES) : 1;

    localparam logic [15:0] GAIN_RESET = 16'd3277;
    localparam logic [7:0]  NOTE_RESET [MAP_REGS] = '{8'd36, 8'd56, 8'd42, 8'd35};

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_DESC = 2'd1,
        CMD_NOTE = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_GAIN  = 3'd0,
        REG_NOTE0 = 3'd1,
        REG_NOTE1 = 3'd2,
        REG_NOTE2 = 3'd3,
        REG_NOTE3 = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_ADDR,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic            accept;     // single-cycle word (load, descriptor, note)
        logic            tick_start;
        logic            disp_step;
        logic            mix_addr;
        logic            mix_mul;
        logic            mix_acc;
        logic            out_load;
        logic [VI_W-1:0] voice;
    } dp_ctrl_t;

    typedef struct packed {
        logic chunk_zero;
        logic queue_empty;
        logic out_full;
    } dp_stat_t;

    // signed product to Q0.16-scaled sample, truncated toward zero
    function automatic logic [15:0] scale_trunc(input logic signed [32:0] p);
        logic signed [32:0] q;
        q = p >>> 16;
        if (p[32] && (p[15:0] != 16'd0))
            q = q + 33'sd1;
        return q[15:0];
    endfunction

    function automatic logic [QA_W-1:0] q_next(input logic [QA_W-1:0] p);
        if (p == QA_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + QA_W'(1);
    endfunction

endpackage

FILE: rtl/drum_sample_voice_mixer.sv
// Polyphonic drum-sample mixer. Load, descriptor and note-on words are taken
// while idle. A frame tick is accepted, then each voice slot is mixed in turn
// (memory read, gain multiply, accumulate), then the output is loaded; on the
// first tick of each chunk a dispatch pass, one step per queued note, runs
// before the mix. A new word is taken while a result waits at the output;
// a tick then holds in its output-load step until that result is taken.
module drum_sample_voice_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [17:0] frame_address,
    input  logic [31:0] frame_word,
    input  logic [1:0]  instrument,
    input  logic [2:0]  layer,
    input  logic [17:0] start_frame,
    input  logic [18:0] length_frames,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic [3:0]  voices_active
);
    import dsvm_pkg::*;

    dp_ctrl_t ctl;
    dp_stat_t stat;

    dsvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .ctl      (ctl)
    );

    dsvm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .frame_address (frame_address),
        .frame_word    (frame_word),
        .instrument    (instrument),
        .layer         (layer),
        .start_frame   (start_frame),
        .length_frames (length_frames),
        .note          (note),
        .velocity      (velocity),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .voices_active (voices_active)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(voices_active) <= VOICE_COUNT))
        else $error("voice count above slot count");

    a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command != CMD_TICK)) |=> !in_stall)
        else $error("non-tick word did not finish in one cycle");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command == CMD_TICK)) |=> in_stall)
        else $error("tick accepted without busy");

endmodule

FILE: rtl/dsvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/dsvm_ctrl.sv
// Controller state machine of the mixer: input handshake, dispatch pass,
// per-voice mix sequence and output load. Depends on dsvm_pkg.
module dsvm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  dsvm_pkg::dp_stat_t stat,
    output dsvm_pkg::dp_ctrl_t ctl
);
    import dsvm_pkg::*;

    state_t          state_reg, state_next;
    logic [VI_W-1:0] voice_reg, voice_next;
    logic            acc_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            voice_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            voice_reg <= voice_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        voice_next = voice_reg;
        ctl        = '0;
        ctl.voice  = voice_reg;
        in_stall   = (state_reg != S_IDLE);
        acc_in     = in_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (cmd_t'(command) == CMD_TICK)
                    begin
                        ctl.tick_start = 1'b1;
                        voice_next     = '0;
                        state_next     = stat.chunk_zero ? S_DISP : S_ADDR;
                    end
                    else
                        ctl.accept = 1'b1;
                end
            end
            S_DISP:
            begin
                if (stat.queue_empty)
                    state_next = S_ADDR;
                else
                    ctl.disp_step = 1'b1;
            end
            S_ADDR:
            begin
                ctl.mix_addr = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                ctl.mix_mul = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                ctl.mix_acc = 1'b1;
                if (voice_reg == VI_W'(VOICE_COUNT - 1))
                    state_next = S_OUT;
                else
                begin
                    voice_next = voice_reg + VI_W'(1);
                    state_next = S_ADDR;
                end
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/dsvm_dp.sv
// Datapath of the mixer: config registers, descriptors, note queue, voice
// slots, sample memory, gain multipliers, accumulators and output register.
// Depends on dsvm_pkg and dsvm_ram.
module dsvm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  dsvm_pkg::dp_ctrl_t ctl,
    output dsvm_pkg::dp_stat_t stat,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic [17:0]        frame_address,
    input  logic [31:0]        frame_word,
    input  logic [1:0]         instrument,
    input  logic [2:0]         layer,
    input  logic [17:0]        start_frame,
    input  logic [18:0]        length_frames,
    input  logic [6:0]         note,
    input  logic [6:0]         velocity,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        left_out,
    output logic [15:0]        right_out,
    output logic [3:0]         voices_active
);
    import dsvm_pkg::*;

    logic [15:0]      gain_reg;
    logic [7:0]       map_reg [MAP_REGS];
    logic [17:0]      lstart_reg [DESC_COUNT];
    logic [18:0]      llen_reg [DESC_COUNT];
    logic [6:0]       pnote_reg [QUEUE_DEPTH];
    logic [6:0]       pvel_reg [QUEUE_DEPTH];
    logic [QA_W-1:0]  head_reg, tail_reg;
    logic [VOICE_COUNT-1:0] vact_reg;
    logic [LI_W-1:0]  vli_reg [VOICE_COUNT];
    logic [18:0]      vpos_reg [VOICE_COUNT];
    logic [CH_W-1:0]  chunk_reg;
    logic             contrib_reg, contrib2_reg;
    logic signed [32:0] prod_l_reg, prod_r_reg;
    logic [15:0]      acc_l_reg, acc_r_reg;
    logic             ovalid_reg;
    logic [15:0]      left_reg, right_reg;
    logic [3:0]       count_reg;

    logic [31:0]      rdata;

    // note to instrument, lowest register wins
    function automatic logic [IN_W:0] lookup(input logic [6:0] n);
        logic [IN_W:0] r;
        r = '0;
        for (int k = MAPPED - 1; k >= 0; k--)
            if (map_reg[k] == {1'b0, n})
                r = {1'b1, IN_W'(k)};
        return r;
    endfunction

    cmd_t             cmd;
    logic [IN_W:0]    in_hit, dq_hit;
    logic             load_ok, desc_ok;
    logic [EXT_W-1:0] load_ext;
    logic [LI_W-1:0]  desc_idx;
    logic             free_found;
    logic [VI_W-1:0]  free_idx;
    logic [9:0]       vel6;
    logic [2:0]       lyr;
    logic [LI_W-1:0]  new_li;
    logic [6:0]       dq_vel;
    logic [VI_W-1:0]  v;
    logic [LI_W-1:0]  cur_li;
    logic [18:0]      cur_len, cur_pos, pos_inc;
    logic [EXT_W-1:0] rd_ext;
    logic             cur_play;
    logic [VC_W-1:0]  act_cnt;

    always_comb
    begin
        cmd      = cmd_t'(command);
        in_hit   = lookup(note);
        dq_hit   = lookup(pnote_reg[tail_reg]);
        dq_vel   = pvel_reg[tail_reg];
        load_ext = EXT_W'(frame_address);
        load_ok  = load_ext < EXT_W'(SAMPLE_FRAMES);
        desc_ok  = (32'(instrument) < INSTRUMENT_COUNT) && (32'(layer) < LAYER_COUNT);
        desc_idx = LI_W'(32'(instrument) * LAYER_COUNT + 32'(layer));

        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
            if (!vact_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VI_W'(i);
            end
        vel6 = 10'(dq_vel) * 10'(LAYER_SPLIT);
        lyr  = vel6[9:7];
        if (32'(lyr) > LAYER_COUNT - 1)
            lyr = 3'(LAYER_COUNT - 1);
        new_li = LI_W'(32'(dq_hit[IN_W-1:0]) * LAYER_COUNT + 32'(lyr));

        v        = ctl.voice;
        cur_li   = vli_reg[v];
        cur_len  = llen_reg[cur_li];
        cur_pos  = vpos_reg[v];
        pos_inc  = cur_pos + 19'd1;
        cur_play = vact_reg[v] && (cur_pos < cur_len);
        rd_ext   = EXT_W'(lstart_reg[cur_li]) + EXT_W'(cur_pos);

        act_cnt = '0;
        for (int i = 0; i < VOICE_COUNT; i++)
            act_cnt = act_cnt + VC_W'(vact_reg[i]);
    end

    dsvm_ram #(
        .WIDTH (32),
        .DEPTH (SAMPLE_FRAMES)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ctl.accept && (cmd == CMD_LOAD) && load_ok),
        .waddr (load_ext[SA_W-1:0]),
        .wdata (frame_word),
        .raddr (rd_ext[SA_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            for (int k = 0; k < MAP_REGS; k++)
                map_reg[k] <= NOTE_RESET[k];
            for (int i = 0; i < DESC_COUNT; i++)
            begin
                lstart_reg[i] <= '0;
                llen_reg[i]   <= '0;
            end
            head_reg  <= '0;
            tail_reg  <= '0;
            vact_reg  <= '0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                vli_reg[i]  <= '0;
                vpos_reg[i] <= '0;
            end
            chunk_reg    <= '0;
            contrib_reg  <= 1'b0;
            contrib2_reg <= 1'b0;
            acc_l_reg    <= '0;
            acc_r_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_GAIN:  gain_reg   <= cfg_data;
                    REG_NOTE0: map_reg[0] <= cfg_data[7:0];
                    REG_NOTE1: map_reg[1] <= cfg_data[7:0];
                    REG_NOTE2: map_reg[2] <= cfg_data[7:0];
                    REG_NOTE3: map_reg[3] <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (ctl.accept && (cmd == CMD_DESC) && desc_ok)
            begin
                lstart_reg[desc_idx] <= start_frame;
                llen_reg[desc_idx]   <= length_frames;
            end

            if (ctl.accept && (cmd == CMD_NOTE) && in_hit[IN_W]
                && (q_next(head_reg) != tail_reg))
                head_reg <= q_next(head_reg);

            if (ctl.tick_start)
            begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end

            if (ctl.disp_step)
            begin
                tail_reg <= q_next(tail_reg);
                if (free_found && dq_hit[IN_W])
                begin
                    vli_reg[free_idx]  <= new_li;
                    vpos_reg[free_idx] <= '0;
                    vact_reg[free_idx] <= 1'b1;
                end
            end

            if (ctl.mix_addr)
            begin
                contrib_reg <= cur_play && (rd_ext < EXT_W'(SAMPLE_FRAMES));
                if (vact_reg[v])
                begin
                    if (!cur_play)
                        vact_reg[v] <= 1'b0;
                    else
                    begin
                        vpos_reg[v] <= pos_inc;
                        if (pos_inc >= cur_len)
                            vact_reg[v] <= 1'b0;
                    end
                end
            end

            if (ctl.mix_mul)
                contrib2_reg <= contrib_reg;

            if (ctl.mix_acc && contrib2_reg)
            begin
                acc_l_reg <= acc_l_reg + scale_trunc(prod_l_reg);
                acc_r_reg <= acc_r_reg + scale_trunc(prod_r_reg);
            end

            if (ctl.out_load)
            begin
                ovalid_reg <= 1'b1;
                chunk_reg  <= (chunk_reg == CH_W'(CHUNK_FRAMES - 1)) ? '0
                                                                     : chunk_reg + CH_W'(1);
            end
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.accept && (cmd == CMD_NOTE) && in_hit[IN_W]
            && (q_next(head_reg) != tail_reg))
        begin
            pnote_reg[head_reg] <= note;
            pvel_reg[head_reg]  <= velocity;
        end
        if (ctl.mix_mul)
        begin
            prod_l_reg <= $signed(rdata[15:0]) * $signed({1'b0, gain_reg});
            prod_r_reg <= $signed(rdata[31:16]) * $signed({1'b0, gain_reg});
        end
        if (ctl.out_load)
        begin
            left_reg  <= acc_l_reg;
            right_reg <= acc_r_reg;
            count_reg <= (32'(act_cnt) > 15) ? 4'd15 : 4'(act_cnt);
        end
    end

    assign stat.chunk_zero  = (chunk_reg == '0);
    assign stat.queue_empty = (head_reg == tail_reg);
    assign stat.out_full    = ovalid_reg && out_stall;

    assign out_valid     = ovalid_reg;
    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign voices_active = count_reg;

endmodule

FILE: bench/drum_sample_voice_mixer_tb.sv
// Testbench for drum_sample_voice_mixer: random and directed words on the input
// channel, a scoreboard that predicts every mixed frame. Needs dsvm_pkg.
`timescale 1ns / 1ps

module drum_sample_voice_mixer_tb;
    import dsvm_pkg::*;

    localparam int ITEMS      = 1850;
    localparam int CYCLE_CAP  = 1000000;
    localparam int POOL_BASE  = 20000;
    localparam int SETTLE     = 60;

    typedef struct {
        cmd_t        cmd;
        logic [17:0] addr;
        logic [31:0] data;
        logic [1:0]  inst;
        logic [2:0]  lay;
        logic [17:0] start;
        logic [18:0] len;
        logic [6:0]  note;
        logic [6:0]  vel;
    } word_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [3:0]  count;
    } mix_t;

    class mix_scoreboard;
        bit [31:0]   frames [int];
        bit [17:0]   lstart [DESC_COUNT];
        bit [18:0]   llen [DESC_COUNT];
        bit [6:0]    qnote [QUEUE_DEPTH];
        bit [6:0]    qvel [QUEUE_DEPTH];
        int          qhead, qtail;
        bit          vact [VOICE_COUNT];
        int          vlay [VOICE_COUNT];
        int          vpos [VOICE_COUNT];
        int          chunk;
        bit [15:0]   gain;
        bit [7:0]    nmap [MAP_REGS];
        mix_t        expected_frames [$];
        int          errors;

        function new();
            gain = GAIN_RESET;
            for (int k = 0; k < MAP_REGS; k++)
                nmap[k] = NOTE_RESET[k];
        endfunction

        function void write_reg(reg_idx_t idx, bit [15:0] v);
            if (idx == REG_GAIN)
                gain = v;
            else
                nmap[int'(idx) - 1] = v[7:0];
        endfunction

        function int find_inst(bit [6:0] n);
            for (int k = 0; k < MAPPED; k++)
                if (nmap[k] == {1'b0, n})
                    return k;
            return -1;
        endfunction

        // signed sample times unsigned gain, truncated toward zero
        function bit [15:0] scaled(bit [15:0] raw);
            longint p;
            longint q;
            p = longint'($signed(raw)) * longint'(gain);
            q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
            return q[15:0];
        endfunction

        function void note_word(word_t w);
            int li;
            int inst;
            int lay;
            int a;
            bit [31:0] fw;
            mix_t m;
            case (w.cmd)
                CMD_LOAD: frames[int'(w.addr)] = w.data;
                CMD_DESC: begin
                    if (w.lay < LAYER_COUNT) begin
                        li = int'(w.inst) * LAYER_COUNT + int'(w.lay);
                        lstart[li] = w.start;
                        llen[li] = w.len;
                    end
                end
                CMD_NOTE: begin
                    if (find_inst(w.note) >= 0 && (qhead + 1) % QUEUE_DEPTH != qtail) begin
                        qnote[qhead] = w.note;
                        qvel[qhead] = w.vel;
                        qhead = (qhead + 1) % QUEUE_DEPTH;
                    end
                end
                default: begin
                    if (chunk == 0) begin
                        while (qtail != qhead) begin
                            for (int v = 0; v < VOICE_COUNT; v++) begin
                                if (!vact[v]) begin
                                    inst = find_inst(qnote[qtail]);
                                    if (inst >= 0) begin
                                        lay = (int'(qvel[qtail]) * LAYER_SPLIT) / 128;
                                        if (lay > LAYER_COUNT - 1)
                                            lay = LAYER_COUNT - 1;
                                        vlay[v] = inst * LAYER_COUNT + lay;
                                        vpos[v] = 0;
                                        vact[v] = 1;
                                    end
                                    break;
                                end
                            end
                            qtail = (qtail + 1) % QUEUE_DEPTH;
                        end
                    end
                    m = '{16'd0, 16'd0, 4'd0};
                    for (int v = 0; v < VOICE_COUNT; v++) begin
                        if (!vact[v])
                            continue;
                        li = vlay[v] % DESC_COUNT;
                        if (vpos[v] >= int'(llen[li])) begin
                            vact[v] = 0;
                            continue;
                        end
                        a = int'(lstart[li]) + vpos[v];
                        fw = (a < SAMPLE_FRAMES && frames.exists(a)) ? frames[a] : 32'd0;
                        m.left = m.left + scaled(fw[15:0]);
                        m.right = m.right + scaled(fw[31:16]);
                        vpos[v]++;
                        if (vpos[v] >= int'(llen[li]))
                            vact[v] = 0;
                    end
                    for (int v = 0; v < VOICE_COUNT; v++)
                        if (vact[v] && m.count != 4'd15)
                            m.count++;
                    chunk = (chunk + 1) % CHUNK_FRAMES;
                    expected_frames.push_back(m);
                end
            endcase
        endfunction

        function void check_result(mix_t r);
            mix_t e;
            if (expected_frames.size() == 0) begin
                $error("unexpected frame: left_out %0d", $signed(r.left));
                errors++;
                return;
            end
            e = expected_frames.pop_front();
            if (r.left !== e.left) begin
                $error("left_out expected %0d got %0d", $signed(e.left), $signed(r.left));
                errors++;
            end
            if (r.right !== e.right) begin
                $error("right_out expected %0d got %0d", $signed(e.right), $signed(r.right));
                errors++;
            end
            if (r.count !== e.count) begin
                $error("voices_active expected %0d got %0d", e.count, r.count);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [17:0] frame_address;
    logic [31:0] frame_word;
    logic [1:0]  instrument;
    logic [2:0]  layer;
    logic [17:0] start_frame;
    logic [18:0] length_frames;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic        out_valid;
    logic        out_stall;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [3:0]  voices_active;

    mix_scoreboard sb;
    int  sent;
    int  got;
    int  cycles;
    bit  calm;

    drum_sample_voice_mixer dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: random stall bursts, one long hold to back up the input.
    initial begin
        mix_t r;
        bit   take;
        bit   held;
        int   stall_left;
        held = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            take = out_valid && !out_stall;
            r = '{left_out, right_out, voices_active};
            @(posedge clk);
            if (take) begin
                sb.check_result(r);
                got++;
            end
            if (got >= 150 && !held) begin
                held = 1;
                stall_left = 700;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    function automatic word_t rand_word(cmd_t c);
        word_t w;
        w.cmd   = c;
        w.addr  = 18'($urandom);
        w.data  = $urandom;
        w.inst  = 2'($urandom);
        w.lay   = 3'($urandom_range(0, 5));
        w.start = 18'($urandom);
        w.len   = 19'($urandom_range(0, 4));
        w.note  = 7'($urandom);
        w.vel   = 7'($urandom);
        return w;
    endfunction

    // called at a rising edge; returns at the edge that took the word, or after a random idle gap that follows it
    task automatic send(word_t w);
        bit ok;
        in_valid      <= 1'b1;
        command       <= w.cmd;
        frame_address <= w.addr;
        frame_word    <= w.data;
        instrument    <= w.inst;
        layer         <= w.lay;
        start_frame   <= w.start;
        length_frames <= w.len;
        note          <= w.note;
        velocity      <= w.vel;
        do begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end while (!ok);
        sb.note_word(w);
        sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic load(int a, logic [31:0] d);
        word_t w;
        w = rand_word(CMD_LOAD);
        w.addr = 18'(a);
        w.data = d;
        send(w);
    endtask

    // loads every unloaded frame the descriptor can reach before writing it
    task automatic set_layer(int i, int l, int s, int n);
        word_t w;
        for (int a = s; a < s + n && a < SAMPLE_FRAMES; a++)
            if (!sb.frames.exists(a))
                load(a, $urandom);
        w = rand_word(CMD_DESC);
        w.inst = 2'(i);
        w.lay = 3'(l);
        w.start = 18'(s);
        w.len = 19'(n);
        send(w);
    endtask

    task automatic note_on(logic [6:0] n, logic [6:0] v);
        word_t w;
        w = rand_word(CMD_NOTE);
        w.note = n;
        w.vel = v;
        send(w);
    endtask

    task automatic tick();
        send(rand_word(CMD_TICK));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] vals [5]);
        for (int i = 0; i < 5; i++) begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(reg_idx_t'(i), vals[i]);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            load($urandom_range(0, SAMPLE_FRAMES - 1), $urandom);
        end else if (r < 14) begin
            k = $urandom_range(0, 99);
            if (k < 15)
                set_layer($urandom_range(0, 3), $urandom_range(0, 7),
                          $urandom_range(0, SAMPLE_FRAMES - 1), $urandom_range(1, 3));
            else if (k < 25)
                set_layer($urandom_range(0, 3), $urandom_range(0, 7),
                          POOL_BASE + $urandom_range(0, 500), 0);
            else if (k < 88)
                set_layer($urandom_range(0, 3), $urandom_range(0, 7),
                          POOL_BASE + $urandom_range(0, 500), $urandom_range(1, 60));
            else
                set_layer($urandom_range(0, 3), $urandom_range(0, 7),
                          POOL_BASE + $urandom_range(0, 300), $urandom_range(61, 300));
        end else if (r < 40) begin
            k = $urandom_range(0, 3);
            if ($urandom_range(0, 4) != 0 && sb.nmap[k] < 8'd128)
                note_on(sb.nmap[k][6:0], 7'($urandom));
            else
                note_on(7'($urandom), 7'($urandom));
        end else begin
            tick();
        end
    endtask

    initial begin
        logic [15:0] regs [5];
        int          quota;
        sb = new();
        clk = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        command = CMD_LOAD;
        frame_address = '0;
        frame_word = '0;
        instrument = '0;
        layer = '0;
        start_frame = '0;
        length_frames = '0;
        note = '0;
        velocity = '0;
        out_stall = 0;
        sent = 0;
        got = 0;
        cycles = 0;
        calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme samples, memory edge, ignored layers, layer extremes
        load(0, 32'h8000_7FFF);
        load(1, 32'hFFFF_FFFF);
        load(SAMPLE_FRAMES - 1, 32'h7FFF_8000);
        set_layer(0, 0, 0, 2);
        set_layer(3, 5, SAMPLE_FRAMES - 1, SAMPLE_FRAMES);
        set_layer(3, 6, 5, 1);
        set_layer(2, 7, 5, 1);
        note_on(7'd36, 7'd0);
        note_on(7'd35, 7'd127);
        note_on(7'd0, 7'd64);
        tick();
        tick();
        tick();
        set_layer(3, 5, SAMPLE_FRAMES - 1, 0);  // shrink under a playing voice
        tick();
        tick();

        quota = (ITEMS - sent) / 6;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 0)
                regs = '{16'd0, 16'd36, 16'd36, 16'd128, 16'd0};
            else if (ph == 1)
                regs = '{16'hFFFF, 16'd127, 16'd56, 16'd42, 16'd35};
            else
                for (int i = 0; i < 5; i++)
                    regs[i] = (i == 0) ? 16'($urandom) :
                              ($urandom_range(0, 4) == 0) ? 16'd128 : 16'($urandom_range(0, 127));
            write_regs(regs);
            while (sent < ITEMS - (5 - ph) * quota) begin
                if (sent > ITEMS - 150)
                    calm = 1;
                random_word();
            end
        end

        settle();
        if (sb.errors == 0 && sb.expected_frames.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dsvm_pkg.sv
rtl/dsvm_ram.sv
rtl/dsvm_ctrl.sv
rtl/dsvm_dp.sv
rtl/drum_sample_voice_mixer.sv
bench/drum_sample_voice_mixer_tb.sv
